[hw/rtl/pipfc_pkg.sv]
package pipfc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegCentreX  = 3'd0,
    RegCentreY  = 3'd1,
    RegCentreZ  = 3'd2,
    RegNormalX  = 3'd3,
    RegNormalY  = 3'd4,
    RegNormalZ  = 3'd5,
    RegDelOut   = 3'd6,
    RegVtxCount = 3'd7
  } reg_idx_e;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

endpackage

[hw/rtl/point_in_polygon_fan_classifier.sv]
// Point-in-polygon classifier over a triangle fan.
// s_axis: one word per item. tdata carries vertex_slot, point_x, point_y,
// point_z, selected (low to high); tuser carries req_type (0 load, 1 query).
// m_axis: one word per item; tdata carries inside_res then delete_flag.
// cfg: cfg_valid_i/cfg_ready_o with index 0..7 and data; write only while idle.
// Items pass a two-entry input queue, then a sequencing engine that takes a
// word from the queue's registered output whenever the engine is idle.
// A load, or a query with vertex count 0, goes from idle straight to the output
// state, where its result waits until taken.
// A query walks n vertices (count saturated to MAX_VERTICES): per edge two
// table reads and a load step, then per side one step for the edge normal,
// split multiply-accumulate for the two dot products, low then high half of
// each normal component, and one decision step.
// Items run one at a time: the engine takes the next word the cycle after its
// result is taken.
// Results wait in the engine until taken; while m_axis stalls the queue still
// takes up to two further words.
// Reset empties the queue and restores the register defaults; the vertex table
// is not cleared and holds undefined data until loaded.
module point_in_polygon_fan_classifier #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned COORD_BITS   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((3*COORD_BITS+12)/8)*8-1:0] s_axis_tdata,  // vertex_slot, point_x, point_y, point_z, selected
  input  logic [0:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // inside_res, delete_flag
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned TdW = ((3 * COORD_BITS + 12) / 8) * 8;
  localparam int unsigned QW  = TdW + 1;

  logic signed [COORD_BITS-1:0] cen_q [3], nrm_q [3];
  logic                         del_out_q;
  logic [4:0]                   vcnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0; cen_q[1] <= '0; cen_q[2] <= '0;
      nrm_q[0] <= '0; nrm_q[1] <= '0; nrm_q[2] <= COORD_BITS'(1);
      del_out_q <= 1'b1; vcnt_q <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (pipfc_pkg::reg_idx_e'(cfg_index_i))
        pipfc_pkg::RegCentreX:  cen_q[0] <= cfg_data_i[COORD_BITS-1:0];
        pipfc_pkg::RegCentreY:  cen_q[1] <= cfg_data_i[COORD_BITS-1:0];
        pipfc_pkg::RegCentreZ:  cen_q[2] <= cfg_data_i[COORD_BITS-1:0];
        pipfc_pkg::RegNormalX:  nrm_q[0] <= cfg_data_i[COORD_BITS-1:0];
        pipfc_pkg::RegNormalY:  nrm_q[1] <= cfg_data_i[COORD_BITS-1:0];
        pipfc_pkg::RegNormalZ:  nrm_q[2] <= cfg_data_i[COORD_BITS-1:0];
        pipfc_pkg::RegDelOut:   del_out_q <= cfg_data_i[0];
        pipfc_pkg::RegVtxCount: vcnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic          qv, qr;
  logic [QW-1:0] qd;

  pipfc_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  ({s_axis_tuser, s_axis_tdata}),
    .out_valid_o(qv),
    .out_ready_i(qr),
    .out_data_o (qd)
  );

  logic ins, del;

  pipfc_engine #(.MaxVertices(MAX_VERTICES), .CoordBits(COORD_BITS)) u_engine (
    .clk_i, .rst_ni,
    .in_valid_i   (qv),
    .in_ready_o   (qr),
    .req_type_i   (qd[QW-1]),
    .vertex_slot_i(qd[3:0]),
    .px_i         (qd[4 +: COORD_BITS]),
    .py_i         (qd[4 + COORD_BITS +: COORD_BITS]),
    .pz_i         (qd[4 + 2 * COORD_BITS +: COORD_BITS]),
    .selected_i   (qd[4 + 3 * COORD_BITS]),
    .cen_i        (cen_q),
    .nrm_i        (nrm_q),
    .del_out_i    (del_out_q),
    .vcount_i     (vcnt_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .inside_o     (ins),
    .delete_o     (del)
  );

  assign m_axis_tdata = {6'd0, del, ins};

`ifndef SYNTHESIS
  a_out_ins_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] && !del_out_q |-> !m_axis_tdata[1])
    else $error("flag mismatch");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
`endif

endmodule

[hw/rtl/pipfc_queue.sv]
module pipfc_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= ~wr_q;
      if (out_valid_o && out_ready_i) rd_q <= ~rd_q;
      unique case ({in_valid_i && in_ready_o, out_valid_o && out_ready_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/pipfc_engine.sv]
module pipfc_engine #(
  parameter int unsigned MaxVertices = 16,
  parameter int unsigned CoordBits   = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [3:0]                       vertex_slot_i,
  input  logic signed [CoordBits-1:0]      px_i,
  input  logic signed [CoordBits-1:0]      py_i,
  input  logic signed [CoordBits-1:0]      pz_i,
  input  logic                             selected_i,
  input  logic signed [CoordBits-1:0]      cen_i [3],
  input  logic signed [CoordBits-1:0]      nrm_i [3],
  input  logic                             del_out_i,
  input  logic [4:0]                       vcount_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             inside_o,
  output logic                             delete_o
);

  localparam int unsigned IdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam int unsigned DW = CoordBits + 4;
  localparam int unsigned NW = 2 * DW + 2;
  localparam int unsigned SW = NW + DW + 3;
  localparam int unsigned HW = NW / 2;
  localparam int unsigned MW = DW + 2;

  typedef enum logic [3:0] {
    StIdle, StRdA, StRdB, StNorm, StDot, StAcc, StNext, StOut
  } state_e;

  logic signed [CoordBits-1:0] vtab_q [MaxVertices][3];
  logic signed [CoordBits-1:0] va_q [3], vb_q [3], vrd_q [3];
  logic signed [CoordBits-1:0] p_q [3];
  state_e                      st_q;
  logic [IdxW-1:0]             i_q;
  logic [CntW-1:0]             n_q;
  logic [1:0]                  side_q;
  logic                        tri_ok_q, inside_q, sel_q, outv_q;
  logic signed [NW-1:0]        nv_q [3];
  logic signed [SW-1:0]        s_q, d_q;
  logic [2:0]                  acc_q;
  logic [IdxW-1:0]             rd_idx;
  logic [IdxW-1:0]             i_next;

  logic signed [DW-1:0] e [3], g [3], t [3];
  logic signed [DW-1:0] cx [3];
  logic signed [NW-1:0] nn [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (side_q)
        2'd0: begin
          e[k] = DW'(va_q[k]) - DW'(vb_q[k]);
          g[k] = DW'(2) * DW'(cen_i[k]) - DW'(va_q[k]) - DW'(vb_q[k]);
          t[k] = DW'(2) * DW'(p_q[k]) - DW'(va_q[k]) - DW'(vb_q[k]);
        end
        2'd1: begin
          e[k] = DW'(cen_i[k]) - DW'(va_q[k]);
          g[k] = DW'(2) * DW'(vb_q[k]) - DW'(va_q[k]) - DW'(cen_i[k]);
          t[k] = DW'(2) * DW'(p_q[k]) - DW'(va_q[k]) - DW'(cen_i[k]);
        end
        default: begin
          e[k] = DW'(vb_q[k]) - DW'(cen_i[k]);
          g[k] = DW'(2) * DW'(va_q[k]) - DW'(vb_q[k]) - DW'(cen_i[k]);
          t[k] = DW'(2) * DW'(p_q[k]) - DW'(vb_q[k]) - DW'(cen_i[k]);
        end
      endcase
      cx[k] = DW'(nrm_i[k]);
    end
    // side 0 uses (b-a)x n = n x (a-b); side 1 uses n x (c-a); side 2 uses (c-b)x n = n x (b-c); all n x e
    nn[0] = NW'(cx[1] * e[2]) - NW'(cx[2] * e[1]);
    nn[1] = NW'(cx[2] * e[0]) - NW'(cx[0] * e[2]);
    nn[2] = NW'(cx[0] * e[1]) - NW'(cx[1] * e[0]);
  end

  assign i_next = (32'(i_q) + 1 < 32'(n_q)) ? IdxW'(32'(i_q) + 1) : '0;
  assign rd_idx = (st_q == StRdA) ? i_q : i_next;

  // one normal component half per cycle: low half first, then high half
  logic [1:0]           acc_k;
  logic signed [MW-1:0] m_op;
  logic signed [NW-1:0] pp_s, pp_d;
  always_comb begin
    acc_k = acc_q[2:1];
    if (acc_q[0]) m_op = MW'($signed(nv_q[acc_k][NW-1:HW]));
    else m_op = {1'b0, nv_q[acc_k][HW-1:0]};
    pp_s = m_op * g[acc_k];
    pp_d = m_op * t[acc_k];
  end

  logic side_pass;
  always_comb begin
    if (nv_q[0] == '0 && nv_q[1] == '0 && nv_q[2] == '0) side_pass = 1'b0;
    else if (s_q < 0) side_pass = (d_q <= 0);
    else side_pass = (d_q >= 0);
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = outv_q;
  assign inside_o    = inside_q;
  assign delete_o    = sel_q & (inside_q ^ del_out_i);

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i && req_type_i == pipfc_pkg::ReqLoad &&
        32'(vertex_slot_i) < MaxVertices) begin
      vtab_q[IdxW'(vertex_slot_i)][0] <= px_i;
      vtab_q[IdxW'(vertex_slot_i)][1] <= py_i;
      vtab_q[IdxW'(vertex_slot_i)][2] <= pz_i;
    end
    vrd_q <= vtab_q[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; outv_q <= 1'b0; inside_q <= 1'b0; sel_q <= 1'b0;
      i_q <= '0; n_q <= '0; side_q <= '0; tri_ok_q <= 1'b0;
      p_q <= '{default: '0}; va_q <= '{default: '0}; vb_q <= '{default: '0};
      nv_q <= '{default: '0}; s_q <= '0; d_q <= '0; acc_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          p_q[0] <= px_i; p_q[1] <= py_i; p_q[2] <= pz_i;
          inside_q <= 1'b0;
          sel_q <= selected_i & (req_type_i == pipfc_pkg::ReqQuery);
          i_q <= '0;
          n_q <= (32'(vcount_i) > MaxVertices) ? CntW'(MaxVertices) : CntW'(vcount_i);
          if (req_type_i == pipfc_pkg::ReqLoad || vcount_i == '0) begin
            outv_q <= 1'b1; st_q <= StOut;
          end else st_q <= StRdA;
        end
        StRdA: st_q <= StRdB;
        StRdB: begin va_q <= vrd_q; st_q <= StNorm; side_q <= '0; tri_ok_q <= 1'b1; end
        StNorm: begin
          if (side_q == 2'd0) vb_q <= vrd_q;
          st_q <= StDot;
        end
        StDot: begin
          nv_q <= nn; s_q <= '0; d_q <= '0; acc_q <= '0; st_q <= StAcc;
        end
        StAcc: begin
          s_q <= s_q + (acc_q[0] ? (SW'(pp_s) <<< HW) : SW'(pp_s));
          d_q <= d_q + (acc_q[0] ? (SW'(pp_d) <<< HW) : SW'(pp_d));
          if (acc_q == 3'd5) st_q <= StNext;
          else acc_q <= acc_q + 3'd1;
        end
        StNext: begin
          if (side_q == 2'd2) begin
            if (tri_ok_q && side_pass) inside_q <= 1'b1;
            if (32'(i_q) + 1 >= 32'(n_q)) begin
              outv_q <= 1'b1; st_q <= StOut;
            end else begin
              i_q <= IdxW'(32'(i_q) + 1); st_q <= StRdA;
            end
          end else begin
            tri_ok_q <= tri_ok_q & side_pass;
            side_q <= side_q + 2'd1; st_q <= StDot;
          end
        end
        StOut: if (out_ready_i) begin outv_q <= 1'b0; st_q <= StIdle; end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

[verif/tb_point_in_polygon_fan_classifier.sv]
module tb_point_in_polygon_fan_classifier;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec_t;
  typedef struct packed {
    logic in_poly;
    logic del;
  } verdict_t;

  class verdict_board;
    verdict_t pending_q[$];
    int unsigned errors;
    int unsigned checked;

    function void note(verdict_t v);
      pending_q.push_back(v);
    endfunction

    function void check(logic ins, logic del);
      verdict_t want;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: inside_res=%0b delete_flag=%0b", ins, del);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (ins !== want.in_poly) begin
        $error("inside_res: expected %0b, actual %0b", want.in_poly, ins);
        errors++;
      end
      if (del !== want.del) begin
        $error("delete_flag: expected %0b, actual %0b", want.del, del);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  point_in_polygon_fan_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  verdict_board board;

  logic signed [23:0] vtx_x [16];
  logic signed [23:0] vtx_y [16];
  logic signed [23:0] vtx_z [16];
  logic signed [23:0] ctr_x, ctr_y, ctr_z, nrm_x, nrm_y, nrm_z;
  logic               del_outside;
  logic [4:0]         vtx_count;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  int unsigned n_loads, n_queries, n_inside, n_deleted;

  localparam int unsigned WatchLimit = 20000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic vec_t mk(wide_t x, wide_t y, wide_t z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic vec_t vsum(vec_t a, vec_t b);
    return mk(a.x + b.x, a.y + b.y, a.z + b.z);
  endfunction

  function automatic vec_t vdiff(vec_t a, vec_t b);
    return mk(a.x - b.x, a.y - b.y, a.z - b.z);
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    return mk(a.y * b.z - a.z * b.y, a.z * b.x - a.x * b.z, a.x * b.y - a.y * b.x);
  endfunction

  function automatic wide_t vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic bit side_passes(vec_t n, vec_t toward, vec_t t);
    wide_t s, d;
    if (n.x == 0 && n.y == 0 && n.z == 0) return 1'b0;
    s = vdot(toward, n);
    d = vdot(t, n);
    if (s < 0) return d <= 0;
    return d >= 0;
  endfunction

  function automatic bit in_fan_triangle(vec_t a, vec_t b, vec_t c, vec_t n, vec_t p);
    vec_t p2;
    p2 = vsum(p, p);
    return side_passes(vcross(vdiff(b, a), n), vdiff(vdiff(vsum(c, c), a), b),
                       vdiff(vdiff(p2, a), b)) &&
           side_passes(vcross(n, vdiff(c, a)), vdiff(vdiff(vsum(b, b), a), c),
                       vdiff(vdiff(p2, a), c)) &&
           side_passes(vcross(vdiff(c, b), n), vdiff(vdiff(vsum(a, a), b), c),
                       vdiff(vdiff(p2, b), c));
  endfunction

  function automatic verdict_t classify_point(logic signed [23:0] x, logic signed [23:0] y,
                                              logic signed [23:0] z, logic sel);
    verdict_t r;
    int n, j;
    vec_t c, nv, p, a, b;
    r = '0;
    n = (vtx_count > 16) ? 16 : int'(vtx_count);
    c = mk(ctr_x, ctr_y, ctr_z);
    nv = mk(nrm_x, nrm_y, nrm_z);
    p = mk(x, y, z);
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      a = mk(vtx_x[i], vtx_y[i], vtx_z[i]);
      b = mk(vtx_x[j], vtx_y[j], vtx_z[j]);
      if (in_fan_triangle(a, b, c, nv, p)) r.in_poly = 1'b1;
    end
    r.del = sel & (del_outside ? ~r.in_poly : r.in_poly);
    return r;
  endfunction

  task automatic send_word(logic req, logic [3:0] slot, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [23:0] z, logic sel);
    verdict_t v;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, sel, z, y, x, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == pipfc_pkg::ReqLoad) begin
      vtx_x[slot] = x;
      vtx_y[slot] = y;
      vtx_z[slot] = z;
      v = '0;
      n_loads++;
    end else begin
      v = classify_point(x, y, z, sel);
      n_queries++;
      n_inside += v.in_poly;
      n_deleted += v.del;
    end
    board.note(v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(pipfc_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pipfc_pkg::RegCentreX:  ctr_x = val[23:0];
      pipfc_pkg::RegCentreY:  ctr_y = val[23:0];
      pipfc_pkg::RegCentreZ:  ctr_z = val[23:0];
      pipfc_pkg::RegNormalX:  nrm_x = val[23:0];
      pipfc_pkg::RegNormalY:  nrm_y = val[23:0];
      pipfc_pkg::RegNormalZ:  nrm_z = val[23:0];
      pipfc_pkg::RegDelOut:   del_outside = val[0];
      default:                vtx_count = val[4:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(int cx, int cy, int cz, int nx, int ny, int nz, bit dout, int cnt);
    write_reg(pipfc_pkg::RegCentreX, cx);
    write_reg(pipfc_pkg::RegCentreY, cy);
    write_reg(pipfc_pkg::RegCentreZ, cz);
    write_reg(pipfc_pkg::RegNormalX, nx);
    write_reg(pipfc_pkg::RegNormalY, ny);
    write_reg(pipfc_pkg::RegNormalZ, nz);
    write_reg(pipfc_pkg::RegDelOut, 32'(dout));
    write_reg(pipfc_pkg::RegVtxCount, cnt);
  endtask

  function automatic int spread(int r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  function automatic logic signed [23:0] pick(int r, bit full);
    if (full) return 24'($urandom());
    return 24'(spread(r));
  endfunction

  // receive side, idle watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata[0], m_axis_tdata[1]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    int r;
    bit full;
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_loads = 0;
    n_queries = 0;
    n_inside = 0;
    n_deleted = 0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    nrm_x = 0; nrm_y = 0; nrm_z = 1;
    del_outside = 1'b1;
    vtx_count = 5'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // square, then centre and corner points
    for (int i = 0; i < 16; i++) begin
      send_word(pipfc_pkg::ReqLoad, i[3:0], (i % 4 < 2) ? 1000 : -1000,
                (i % 4 == 1 || i % 4 == 2) ? 1000 : -1000, 0, 1'b1);
    end
    send_word(pipfc_pkg::ReqQuery, 4'd0, 0, 0, 0, 1'b1);
    drain();
    write_reg(pipfc_pkg::RegVtxCount, 4);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 0, 0, 0, 1'b1);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 1000, 1000, 0, 1'b0);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 1001, 0, 0, 1'b1);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b1);
    send_word(pipfc_pkg::ReqQuery, 4'hf, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    drain();
    write_all(-8388608, 8388607, 0, 0, 0, 8388607, 1'b0, 0);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 0, 0, 0, 1'b1);
    drain();
    write_all(0, 0, 0, 0, 0, 0, 1'b0, 31);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 0, 0, 0, 1'b1);
    drain();
    // collinear fan: centroid test vanishes
    write_all(3000, 0, 0, 0, 0, -8388608, 1'b0, 16);
    for (int i = 0; i < 16; i++) send_word(pipfc_pkg::ReqLoad, i[3:0], 1000 + i, 0, 0, 1'b0);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 1000, 0, 0, 1'b1);
    send_word(pipfc_pkg::ReqQuery, 4'd0, 1500, 5, 0, 1'b1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      full = (phase == 3 || phase == 6);
      r = (phase % 3 == 0) ? 300 : 4000;
      if (phase == 5) begin
        write_all(8388607, -8388608, 8388607, -8388608, 8388607, -8388608, 1'b1, 16);
      end else if ($urandom_range(0, 3) != 0) begin
        write_all(spread(r / 4), spread(r / 4), spread(r), 0, 0,
                  $urandom_range(0, 1) ? $urandom_range(1, 8388607) : -$urandom_range(1, 8388608),
                  $urandom_range(0, 1), $urandom_range(3, 16));
      end else begin
        write_all(spread(r), spread(r), spread(r), spread(r), spread(r), spread(r),
                  $urandom_range(0, 1), $urandom_range(0, 31));
      end
      for (int i = 0; i < 16; i++) begin
        send_word(pipfc_pkg::ReqLoad, i[3:0], pick(r, full), pick(r, full),
                  (nrm_x == 0 && nrm_y == 0) ? ctr_z + spread(r / 16) : pick(r, full),
                  $urandom_range(0, 1));
      end
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          send_word(pipfc_pkg::ReqLoad, $urandom_range(0, 15), pick(r, full), pick(r, full),
                    pick(r, full), $urandom_range(0, 1));
        end else begin
          send_word(pipfc_pkg::ReqQuery, $urandom_range(0, 15), pick(r, full), pick(r, full),
                    pick(r, full), $urandom_range(0, 1));
        end
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("Covered %0d vertex loads and %0d queries (%0d inside, %0d flagged for delete)",
             n_loads, n_queries, n_inside, n_deleted);
    $display("over four idle/stall mixes and %0d result words checked.", board.checked);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[point_in_polygon_fan_classifier.f]
hw/rtl/pipfc_pkg.sv
hw/rtl/pipfc_queue.sv
hw/rtl/pipfc_engine.sv
hw/rtl/point_in_polygon_fan_classifier.sv
verif/tb_point_in_polygon_fan_classifier.sv
